// ===== rtl/settle_detect_face_classifier_unit_assert.svh =====
// assertion macros shared by the settle detector checker
`ifndef SETTLE_DETECT_FACE_CLASSIFIER_UNIT_ASSERT_SVH
`define SETTLE_DETECT_FACE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SDFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SDFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdfc_pkg.sv =====
// shared constants, types and face axis table for the settle detector
`default_nettype none
package sdfc_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 4;
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;

  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned FACE_W      = 3;
  localparam int unsigned FACE_COUNT  = 6;
  localparam int unsigned AXIS_W      = 10;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic signed [CFG_W-1:0] SETTLE_LOW_RST  = 32'sd1310720;
  localparam logic signed [CFG_W-1:0] SETTLE_HIGH_RST = 32'sd1966080;

  // axis components in q2.8: 0.7 as 179, 1.0 as 256
  localparam logic signed [AXIS_W-1:0] AX_ONE  = 10'sd256;
  localparam logic signed [AXIS_W-1:0] AX_DIAG = 10'sd179;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE_LOW  = 1'b0,
    CFG_SETTLE_HIGH = 1'b1
  } cfg_reg_e;

  // component a (0 x, 1 y, 2 z) of face axis f (0 for face 1)
  function automatic logic signed [AXIS_W-1:0] face_axis(input int unsigned f,
                                                         input int unsigned a);
    logic signed [AXIS_W-1:0] v;
    v = '0;
    unique case (f)
      0: if (a == 0) v = AX_ONE;
      1: if (a != 0) v = -AX_DIAG;
      2: if (a == 1) v = AX_DIAG; else if (a == 2) v = -AX_DIAG;
      3: if (a == 1) v = -AX_DIAG; else if (a == 2) v = AX_DIAG;
      4: if (a != 0) v = AX_DIAG;
      5: if (a == 0) v = -AX_ONE;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sdfc_rest_check.sv =====
// at-rest test: sample dotted with every history entry against two bounds
`default_nettype none
module sdfc_rest_check #(
  parameter int unsigned HistoryDepth = sdfc_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SampleWidth  = sdfc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic [2:0][SampleWidth-1:0]                   sample_i,
  input  logic [HistoryDepth-1:0][2:0][SampleWidth-1:0] hist_i,
  input  logic signed [sdfc_pkg::CFG_W-1:0]             low_i,
  input  logic signed [sdfc_pkg::CFG_W-1:0]             high_i,
  output logic                                          at_rest_o
);
  import sdfc_pkg::*;

  localparam int unsigned ProdW = 2 * SampleWidth;
  localparam int unsigned DotW  = ProdW + 2;
  localparam int unsigned CmpW  = (DotW > CFG_W) ? DotW : CFG_W;

  logic [HistoryDepth-1:0] in_band;

  for (genvar h = 0; h < HistoryDepth; h++) begin : g_lane
    logic signed [ProdW-1:0] px, py, pz;
    logic signed [DotW-1:0]  dot;
    assign px  = ProdW'($signed(hist_i[h][0])) * ProdW'($signed(sample_i[0]));
    assign py  = ProdW'($signed(hist_i[h][1])) * ProdW'($signed(sample_i[1]));
    assign pz  = ProdW'($signed(hist_i[h][2])) * ProdW'($signed(sample_i[2]));
    assign dot = DotW'(px) + DotW'(py) + DotW'(pz);
    assign in_band[h] = (CmpW'(dot) > CmpW'(low_i)) && (CmpW'(dot) < CmpW'(high_i));
  end

  assign at_rest_o = &in_band;

endmodule
`default_nettype wire

// ===== rtl/sdfc_face_sel.sv =====
// face classifier: first strictly largest positive dot against six axes
`default_nettype none
module sdfc_face_sel #(
  parameter int unsigned SampleWidth = sdfc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic [2:0][SampleWidth-1:0]    sample_i,
  output logic [sdfc_pkg::FACE_W-1:0]    face_o
);
  import sdfc_pkg::*;

  localparam int unsigned ProdW = SampleWidth + AXIS_W;
  localparam int unsigned DotW  = ProdW + 2;

  logic signed [FACE_COUNT-1:0][DotW-1:0] fdot;

  for (genvar f = 0; f < FACE_COUNT; f++) begin : g_face
    logic signed [2:0][ProdW-1:0] prod;
    for (genvar a = 0; a < 3; a++) begin : g_ax
      assign prod[a] = ProdW'($signed(sample_i[a])) * ProdW'(face_axis(f, a));
    end
    assign fdot[f] = DotW'($signed(prod[0])) + DotW'($signed(prod[1]))
                   + DotW'($signed(prod[2]));
  end

  always_comb begin
    logic signed [DotW-1:0] best;
    best   = '0;
    face_o = '0;
    for (int f = 0; f < FACE_COUNT; f++) begin
      if ($signed(fdot[f]) > best) begin
        best   = $signed(fdot[f]);
        face_o = FACE_W'(f + 1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/settle_detect_face_classifier_unit.sv =====
// throughput: one item per cycle unless the result stream stalls; the history and
// was-moving state update as an item moves from the input register to the result
// register, so the next item sees it
// reset: history cleared to zero, was-moving cleared, thresholds to 20.0 and 30.0 in
// q16.16, both pipeline stages empty; no clearing pass, ready right after reset
`default_nettype none
module settle_detect_face_classifier_unit #(
  parameter int unsigned HistoryDepth = sdfc_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SampleWidth  = sdfc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample stream in
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // fields from bit 0: accel_x, accel_y, accel_z, zero pad to whole bytes
  input  logic [((3*SampleWidth+7)/8)*8-1:0]     s_axis_tdata,
  // result stream out
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // fields from bit 0: settled_event (1), face_number (3), zero pad
  output logic [sdfc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // threshold register writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [sdfc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sdfc_pkg::CFG_W-1:0]             cfg_data_i
);
  import sdfc_pkg::*;

  localparam int unsigned OutPadW = OUT_TDATA_W - 1 - FACE_W;

  // thresholds, signed q16.16
  logic signed [CFG_W-1:0] low_q, high_q;

  // input register stage
  logic                        a_vld_q;
  logic [2:0][SampleWidth-1:0] a_smp_q;

  // result register stage
  logic              b_vld_q;
  logic              b_evt_q;
  logic [FACE_W-1:0] b_face_q;

  // state kept between items
  logic [HistoryDepth-1:0][2:0][SampleWidth-1:0] hist_q, hist_d;
  logic                                          moving_q, moving_d;

  logic              advance;
  logic              at_rest;
  logic              evt_d;
  logic [FACE_W-1:0] face;

  // the input stage empties whenever the result stage is free or being drained
  assign advance       = a_vld_q && (!b_vld_q || m_axis_tready);
  assign s_axis_tready = !a_vld_q || advance;
  assign cfg_ready_o   = 1'b1;

  sdfc_rest_check #(
    .HistoryDepth(HistoryDepth),
    .SampleWidth (SampleWidth)
  ) u_rest (
    .sample_i (a_smp_q),
    .hist_i   (hist_q),
    .low_i    (low_q),
    .high_i   (high_q),
    .at_rest_o(at_rest)
  );

  sdfc_face_sel #(
    .SampleWidth(SampleWidth)
  ) u_face (
    .sample_i(a_smp_q),
    .face_o  (face)
  );

  // one-shot event: first at-rest item after any moving item
  always_comb begin
    evt_d    = at_rest && moving_q;
    moving_d = !at_rest;
    // newest sample goes to entry 0, the rest move up one index
    hist_d    = hist_q << (3 * SampleWidth);
    hist_d[0] = a_smp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= SETTLE_LOW_RST;
      high_q   <= SETTLE_HIGH_RST;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      hist_q   <= '0;
      moving_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_SETTLE_LOW:  low_q  <= $signed(cfg_data_i);
          CFG_SETTLE_HIGH: high_q <= $signed(cfg_data_i);
        endcase
      end
      if (s_axis_tready) begin
        a_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        b_vld_q  <= 1'b1;
        hist_q   <= hist_d;
        moving_q <= moving_d;
      end else if (m_axis_tready) begin
        b_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_smp_q <= s_axis_tdata[3*SampleWidth-1:0];
    end
    if (advance) begin
      b_evt_q  <= evt_d;
      b_face_q <= evt_d ? face : '0;
    end
  end

  assign m_axis_tvalid = b_vld_q;
  assign m_axis_tdata  = {OutPadW'(0), b_face_q, b_evt_q};

endmodule
`default_nettype wire

// ===== rtl/sdfc_checker.sv =====
// port-level checker for the settle detector, bound to the top level
`default_nettype none
`include "settle_detect_face_classifier_unit_assert.svh"
module sdfc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sdfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import sdfc_pkg::*;

  logic              out_fire;
  logic              evt;
  logic [FACE_W-1:0] face;
  logic              last_evt_q, last_evt_d;

  assign out_fire   = m_axis_tvalid && m_axis_tready;
  assign evt        = m_axis_tdata[0];
  assign face       = m_axis_tdata[FACE_W:1];
  assign last_evt_d = out_fire ? evt : last_evt_q;

  // event of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_evt_q <= 1'b0;
    end else begin
      last_evt_q <= last_evt_d;
    end
  end

  // a face is only reported with an event, and never beyond six
  `SDFC_ASSERT_IMPLY(a_face_needs_evt, clk_i, rst_ni, m_axis_tvalid && (face != '0), evt, "face without event")
  `SDFC_ASSERT_IMPLY(a_face_range, clk_i, rst_ni, m_axis_tvalid, face <= FACE_W'(FACE_COUNT), "face out of range")
  // an event clears was-moving, so two delivered items in a row cannot both carry one
  `SDFC_ASSERT_IMPLY(a_evt_one_shot, clk_i, rst_ni, out_fire && evt, !last_evt_q, "repeated settled event")
  // empty result register means the input side can always take an item
  `SDFC_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "stalled while empty")
  `SDFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")

endmodule

bind settle_detect_face_classifier_unit sdfc_checker u_sdfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
